### hdl/uart16_pkg.sv
// ----------------------------------------------------------------------------
// uart16_pkg
// shared types, register offsets and constants of the uart register model
// ----------------------------------------------------------------------------
package uart16_pkg;

  // receive ring
  localparam int RX_DEPTH = 256;
  localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  // command codes
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_RECEIVE = 2'd2;

  // register offsets
  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;
  localparam logic [2:0] OFF_SCR  = 3'd7;

  // fixed values
  localparam logic [7:0] LSR_RX_READY = 8'h61;
  localparam logic [7:0] LSR_IDLE     = 8'h60;
  localparam logic [7:0] IIR_FIFO_ON  = 8'hc0;
  localparam logic [7:0] FCR_MASK     = 8'hc9;
  localparam logic [7:0] IIR_RX_DATA  = 8'h04;
  localparam logic [7:0] IIR_THR_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_pulse;
  } result_t;

  typedef struct packed {
    logic       en;
    ptr_t       addr;
    logic [7:0] data;
  } ring_wr_t;

  function automatic ptr_t ring_next(input ptr_t i);
    ring_next = (i == PTR_W'(RX_DEPTH - 1)) ? '0 : i + PTR_W'(1);
  endfunction

endpackage

### hdl/uart_16550_register_model.sv
// ----------------------------------------------------------------------------
// uart_16550_register_model
// simplified 16550 register file with instant transmitter and receive ring
// ----------------------------------------------------------------------------
// usage notes
// - input stream: one transaction is a bus read, a bus write or a byte
//   received from the line; the kind travels in in_tuser
// - output stream: exactly one result transaction per input transaction,
//   in order: read data, transmit byte with its flag, interrupt pulse
// - path: the input register loads on acceptance, the result register when
//   the held transaction moves on, and the result is offered from there
// - throughput: one transaction per cycle while out_tready holds high; the
//   register file and ring pointers are updated by single-pass logic between the two
// - the receive ring is a block memory with registered read; the byte at
//   the read pointer is prefetched, with forwarding when it is written in
//   the same cycle
// - reset: valid flags, uart registers and ring pointers clear; data payloads are
//   not cleared, nor ring contents, which are never read before being written
// - stall: while out_tready is low the result register holds and the input
//   register keeps one more transaction, after which in_tready drops
// ----------------------------------------------------------------------------
module uart_16550_register_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_offset[2:0], write_data[10:3], rx_byte[18:11], zero
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data[7:0], tx_byte[15:8], irq_pulse[16], zero
  output logic        out_tuser   // tx_valid[0]
);
  import uart16_pkg::*;

  // input register
  logic    in_valid_r;
  item_t   item_r;
  // result register
  logic    out_valid_r;
  result_t res_r;

  logic     fire;
  result_t  res;
  ring_wr_t ring_wr;
  ptr_t     ring_rd_addr;
  logic [7:0] head_byte;

  // the held transaction moves on whenever the result slot is free or draining
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.cmd        <= in_tuser;
      item_r.reg_offset <= in_tdata[2:0];
      item_r.write_data <= in_tdata[10:3];
      item_r.rx_byte    <= in_tdata[18:11];
    end
  end

  uart16_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (item_r),
    .head_byte    (head_byte),
    .ring_wr      (ring_wr),
    .ring_rd_addr (ring_rd_addr),
    .res          (res)
  );

  uart16_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_addr (ring_rd_addr),
    .rd_data (head_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, res_r.irq_pulse, res_r.tx_byte, res_r.read_data};
  assign out_tuser  = res_r.tx_valid;

endmodule

### hdl/uart16_ring.sv
// ----------------------------------------------------------------------------
// uart16_ring
// receive ring storage with registered read and same-cycle write forwarding
// ----------------------------------------------------------------------------
module uart16_ring (
  input  logic                  clk,
  input  uart16_pkg::ring_wr_t  wr,
  input  uart16_pkg::ptr_t      rd_addr,
  output logic [7:0]            rd_data
);
  import uart16_pkg::*;

  logic [7:0] mem [RX_DEPTH];
  logic [7:0] mem_q_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // a write to the slot being read shows up through the forwarding path
  always_ff @(posedge clk) begin
    fwd_r      <= wr.en && (wr.addr == rd_addr);
    fwd_data_r <= wr.data;
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

### hdl/uart16_core.sv
// ----------------------------------------------------------------------------
// uart16_core
// register file, ring pointers and per-transaction decode of the uart model
// ----------------------------------------------------------------------------
module uart16_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  uart16_pkg::item_t     item,
  input  logic [7:0]            head_byte,
  output uart16_pkg::ring_wr_t  ring_wr,
  output uart16_pkg::ptr_t      ring_rd_addr,
  output uart16_pkg::result_t   res
);
  import uart16_pkg::*;

  logic [7:0] lcr_r, lcr_nxt;
  logic [3:0] ier_r, ier_nxt;
  logic [4:0] mcr_r, mcr_nxt;
  logic [7:0] fcr_r, fcr_nxt;
  logic [7:0] dll_r, dll_nxt;
  logic [7:0] dlm_r, dlm_nxt;
  logic [7:0] scr_r, scr_nxt;
  logic [7:0] loop_byte_r, loop_byte_nxt;
  logic       loop_valid_r, loop_valid_nxt;
  logic       thre_pend_r, thre_pend_nxt;
  ptr_t       head_r, head_nxt;
  ptr_t       tail_r, tail_nxt;

  logic dlab;
  logic ring_has;
  logic has_rx;
  ptr_t head_inc;
  ptr_t tail_inc;

  assign dlab     = lcr_r[7];
  assign ring_has = (head_r != tail_r);
  assign has_rx   = loop_valid_r || ring_has;
  assign head_inc = ring_next(head_r);
  assign tail_inc = ring_next(tail_r);

  always_comb begin
    lcr_nxt        = lcr_r;
    ier_nxt        = ier_r;
    mcr_nxt        = mcr_r;
    fcr_nxt        = fcr_r;
    dll_nxt        = dll_r;
    dlm_nxt        = dlm_r;
    scr_nxt        = scr_r;
    loop_byte_nxt  = loop_byte_r;
    loop_valid_nxt = loop_valid_r;
    thre_pend_nxt  = thre_pend_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ring_wr.en     = 1'b0;
    ring_wr.addr   = tail_r;
    ring_wr.data   = item.rx_byte;
    res            = '0;

    case (item.cmd)
      CMD_READ: begin
        case (item.reg_offset)
          OFF_DATA: begin
            if (dlab) begin
              res.read_data = dll_r;
            end else if (loop_valid_r) begin
              res.read_data  = loop_byte_r;
              loop_valid_nxt = 1'b0;
            end else if (ring_has) begin
              res.read_data = head_byte;
              head_nxt      = head_inc;
              res.irq_pulse = (head_inc != tail_r) && ier_r[0];
            end
          end
          OFF_IER: res.read_data = dlab ? dlm_r : {4'b0, ier_r};
          OFF_IIR: begin
            res.read_data = fcr_r[0] ? IIR_FIFO_ON : 8'h00;
            if (has_rx && ier_r[0]) begin
              res.read_data = res.read_data | IIR_RX_DATA;
            end else if (thre_pend_r && ier_r[1]) begin
              res.read_data = res.read_data | IIR_THR_EMPTY;
              thre_pend_nxt = 1'b0;
            end else begin
              res.read_data = res.read_data | IIR_NONE;
            end
          end
          OFF_LCR: res.read_data = lcr_r;
          OFF_MCR: res.read_data = {3'b0, mcr_r};
          OFF_LSR: res.read_data = has_rx ? LSR_RX_READY : LSR_IDLE;
          // loopback: out2->dcd, out1->ri, dtr->dsr, rts->cts
          OFF_MSR: res.read_data = mcr_r[4] ? {mcr_r[3], mcr_r[2], mcr_r[0], mcr_r[1], 4'b0}
                                            : 8'h00;
          default: res.read_data = scr_r;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_offset)
          OFF_DATA: begin
            if (dlab) begin
              dll_nxt = item.write_data;
            end else begin
              if (mcr_r[4]) begin
                loop_byte_nxt  = item.write_data;
                loop_valid_nxt = 1'b1;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte  = item.write_data;
              end
              thre_pend_nxt = 1'b1;
              res.irq_pulse = ier_r[1];
            end
          end
          OFF_IER: begin
            if (dlab) begin
              dlm_nxt = item.write_data;
            end else begin
              ier_nxt       = item.write_data[3:0];
              thre_pend_nxt = 1'b1;
              res.irq_pulse = item.write_data[1];
            end
          end
          OFF_IIR: begin
            fcr_nxt = item.write_data & FCR_MASK;
            if (item.write_data[1]) begin
              loop_valid_nxt = 1'b0;
            end
          end
          OFF_LCR: lcr_nxt = item.write_data;
          OFF_MCR: mcr_nxt = item.write_data[4:0];
          OFF_SCR: scr_nxt = item.write_data;
          default: ;
        endcase
      end
      CMD_RECEIVE: begin
        if (tail_inc != head_r) begin
          ring_wr.en = 1'b1;
          tail_nxt   = tail_inc;
        end
        res.irq_pulse = (tail_nxt != head_r) && ier_r[0];
      end
      default: ;
    endcase

    if (!fire) begin
      ring_wr.en = 1'b0;
    end
  end

  assign ring_rd_addr = fire ? head_nxt : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r        <= '0;
      ier_r        <= '0;
      mcr_r        <= '0;
      fcr_r        <= '0;
      dll_r        <= '0;
      dlm_r        <= '0;
      scr_r        <= '0;
      loop_byte_r  <= '0;
      loop_valid_r <= 1'b0;
      thre_pend_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
    end else if (fire) begin
      lcr_r        <= lcr_nxt;
      ier_r        <= ier_nxt;
      mcr_r        <= mcr_nxt;
      fcr_r        <= fcr_nxt;
      dll_r        <= dll_nxt;
      dlm_r        <= dlm_nxt;
      scr_r        <= scr_nxt;
      loop_byte_r  <= loop_byte_nxt;
      loop_valid_r <= loop_valid_nxt;
      thre_pend_r  <= thre_pend_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
    end
  end

endmodule
